// ----- rtl/nss_pkg.sv -----
// ----------------------------------------------------------------------------
// nss_pkg
// Shared types and constants for the naive substring search block.
// ----------------------------------------------------------------------------
package nss_pkg;

	localparam int POS_W = 31;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	// command codes carried in the cmd field
	localparam logic CMD_NEEDLE   = 1'b0;
	localparam logic CMD_HAYSTACK = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [7:0]       data_byte;
		logic             last_flag;
		logic [POS_W-1:0] start_pos;
	} req_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_pos;
	} rsp_item_t;

	// controls from the sequencer to the matcher
	typedef struct packed {
		logic       needle_wr;
		logic       hay_wr;
		logic [7:0] data;
	} mctl_t;

endpackage

// ----- rtl/nss_matcher.sv -----
// ----------------------------------------------------------------------------
// nss_matcher
// Needle and haystack window shift registers with a parallel compare of the
// window as it stands after the current haystack byte.
// ----------------------------------------------------------------------------
module nss_matcher #(
	parameter int MAX_NEEDLE = 64,
	parameter int LEN_W      = $clog2(MAX_NEEDLE + 1)
) (
	input  logic                clk,
	input  nss_pkg::mctl_t      ctl,
	input  logic [LEN_W-1:0]    len,
	output logic                win_eq
);

	// Needle is kept newest-first like the window, so entry i of the needle
	// lines up with entry i of the window and every compare is at a fixed place.
	logic [7:0] needle_q [MAX_NEEDLE];
	logic [7:0] win_q    [MAX_NEEDLE];
	logic [7:0] win_next [MAX_NEEDLE];
	logic [MAX_NEEDLE-1:0] eq_vec;

	always_comb begin
		win_next[0] = ctl.data;
		for (int i = 1; i < MAX_NEEDLE; i++) begin
			win_next[i] = win_q[i-1];
		end
	end

	for (genvar g = 0; g < MAX_NEEDLE; g++) begin : g_cmp
		// entries at or beyond the needle length do not take part
		assign eq_vec[g] = (needle_q[g] == win_next[g]) || (LEN_W'(g) >= len);
	end

	assign win_eq = &eq_vec;

	always_ff @(posedge clk) begin
		if (ctl.needle_wr) begin
			needle_q[0] <= ctl.data;
			for (int i = 1; i < MAX_NEEDLE; i++) begin
				needle_q[i] <= needle_q[i-1];
			end
		end
		if (ctl.hay_wr) begin
			for (int i = 0; i < MAX_NEEDLE; i++) begin
				win_q[i] <= win_next[i];
			end
		end
	end

endmodule

// ----- rtl/naive_substring_search_top.sv -----
// ----------------------------------------------------------------------------
// naive_substring_search_top
// Streaming substring search: loads a needle, then reports the first
// occurrence of it in each haystack.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | nss_pkg::req_item_t
//  rsp     | out       | rsp_valid/rsp_stall  | nss_pkg::rsp_item_t
//
//  One transaction per cycle is accepted while req_stall is low; a byte is
//  captured in the input register when taken, and its result is captured in
//  the result register when that byte advances out of the input register.
//  The window compare over MAX_NEEDLE bytes sits between the two registers.
//  A result held in the output register by rsp_stall stalls the input while
//  a byte waits in the input register, whether or not that byte has a result.
//  Reset is asynchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module naive_substring_search_top #(
	parameter int MAX_NEEDLE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  nss_pkg::req_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output nss_pkg::rsp_item_t  rsp
);

	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
	localparam int POS_W = nss_pkg::POS_W;

	logic               valid_s1;
	nss_pkg::req_item_t item_s1;
	logic               adv;

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             cmpl_q;
	logic [POS_W-1:0] seen_q;
	logic [POS_W-1:0] base_q;
	logic             done_q;

	logic             is_hay;
	logic [LEN_W-1:0] len_eff;
	logic             room;
	logic [POS_W-1:0] seen_n;
	logic [POS_W-1:0] len_ext;
	logic [POS_W-1:0] base_n;
	logic [POS_W-1:0] pos;
	logic             win_eq;
	logic             hit;
	logic             emit;
	nss_pkg::mctl_t   mctl;

	// input register
	assign adv       = valid_s1 && (!rsp_valid || !rsp_stall);
	assign req_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	// search control
	always_comb begin
		is_hay  = (item_s1.cmd == nss_pkg::CMD_HAYSTACK);
		len_eff = cmpl_q ? '0 : len_q;
		room    = (len_eff < LEN_W'(MAX_NEEDLE));
		seen_n  = (seen_q == nss_pkg::POS_MAX) ? seen_q : seen_q + POS_W'(1);
		len_ext = POS_W'(len_q);
		base_n  = (seen_q == '0) ? item_s1.start_pos : base_q;
		pos     = base_n + (seen_n - len_ext);
		hit     = !done_q && cmpl_q && !ovf_q && (len_q != '0) &&
			(seen_n >= len_ext) && win_eq;
		emit    = is_hay && (hit || (item_s1.last_flag && !done_q));

		mctl.needle_wr = adv && !is_hay && room;
		mctl.hay_wr    = adv && is_hay;
		mctl.data      = item_s1.data_byte;
	end

	nss_matcher #(
		.MAX_NEEDLE (MAX_NEEDLE),
		.LEN_W      (LEN_W)
	) u_matcher (
		.clk    (clk),
		.ctl    (mctl),
		.len    (len_q),
		.win_eq (win_eq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			cmpl_q <= 1'b0;
			seen_q <= '0;
			base_q <= '0;
			done_q <= 1'b0;
		end else if (adv) begin
			if (!is_hay) begin
				// a byte after a finished needle starts a new one
				len_q  <= room ? len_eff + LEN_W'(1) : len_eff;
				ovf_q  <= (ovf_q && !cmpl_q) || !room;
				cmpl_q <= item_s1.last_flag;
				seen_q <= '0;
				done_q <= 1'b0;
			end else begin
				base_q <= base_n;
				seen_q <= item_s1.last_flag ? '0 : seen_n;
				done_q <= item_s1.last_flag ? 1'b0 : (done_q || hit);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv && emit) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			rsp.found     <= hit;
			rsp.match_pos <= hit ? pos : '0;
		end
	end

`ifndef SYNTHESIS
	a_notfound_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.match_pos == '0)
		else $error("not-found result carries a nonzero position");

	a_hit_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_hay && hit && !item_s1.last_flag |=> done_q)
		else $error("match did not close the haystack");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_NEEDLE))
		else $error("needle length beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LEN_W'(MAX_NEEDLE))
		else $error("overflow flagged on a needle that is not full");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && rsp_valid && rsp_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule
